@@ hw/rtl/pidc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

  // Fixed field widths.
  localparam int GAIN_W  = 24;
  localparam int DT_W    = 16;
  localparam int SPLIT_W = 32;
  localparam int WIDE_W  = 2 * SPLIT_W;

  // Signed Q.8 sum of the three terms, and the term magnitude limit of 2^60.
  localparam int SUM_W = 64;
  localparam int MAG_W = 61;
  localparam logic [MAG_W-1:0] TERM_LIM = {1'b1, {(MAG_W-1){1'b0}}};

  // Quotient bits produced per divider step.
  localparam int DIV_RADIX = 2;

  // Configuration register indexes.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_KP      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KI      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KD      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_MIN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OUT_MAX = 3'd4;

  // Operand selection for the shared multiplier.
  typedef logic [2:0] mul_op_t;
  localparam mul_op_t MUL_E_DT  = 3'd0;
  localparam mul_op_t MUL_KP_E  = 3'd1;
  localparam mul_op_t MUL_KI_LO = 3'd2;
  localparam mul_op_t MUL_KI_HI = 3'd3;
  localparam mul_op_t MUL_KD_DE = 3'd4;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic    load;
    logic    clear;
    mul_op_t mul_op;
    logic    int_upd;
    logic    p_load;
    logic    plo_load;
    logic    phi_load;
    logic    div_load;
    logic    div_step;
    logic    sum_load;
    logic    out_load;
  } pidc_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/pidc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pidc_div #(
  parameter int NUM_W = 72,
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic             step,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic      [NUM_W-1:0] quotient
);
  import pidc_pkg::*;

  logic [DEN_W:0]   rem;
  logic [DEN_W:0]   rem_next;
  logic [NUM_W-1:0] quo;
  logic [NUM_W-1:0] quo_next;
  logic [DEN_W-1:0] den;

  // Restoring division; the dividend shifts out of quo as quotient bits shift in.
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < DIV_RADIX; k++) begin
      rem_next = {rem_next[DEN_W-1:0], quo_next[NUM_W-1]};
      quo_next = {quo_next[NUM_W-2:0], 1'b0};
      if (rem_next >= {1'b0, den}) begin
        rem_next    = rem_next - {1'b0, den};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

@@ hw/rtl/pidc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pidc_datapath #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 48,
  parameter int DIV_STEPS  = 36,
  parameter int CFG_W      = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [pidc_pkg::REG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  input  wire logic signed [DATA_WIDTH-1:0]  setpoint,
  input  wire logic signed [DATA_WIDTH-1:0]  measured,
  input  wire logic [pidc_pkg::DT_W-1:0]     dt,
  input  wire pidc_pkg::pidc_cmd_t           cmd,
  output logic [DATA_WIDTH-1:0]              drive,
  output logic                               clamped
);
  import pidc_pkg::*;

  localparam int E_W   = DATA_WIDTH + 1;
  localparam int DE_W  = DATA_WIDTH + 2;
  localparam int MB_W  = (DATA_WIDTH + 1 > SPLIT_W) ? DATA_WIDTH + 1 : SPLIT_W;
  localparam int PW    = GAIN_W + MB_W;
  localparam int SW    = ((ACC_WIDTH > DATA_WIDTH + DT_W + 1) ?
                          ACC_WIDTH : DATA_WIDTH + DT_W + 1) + 1;
  localparam int NUM_W = DIV_RADIX * DIV_STEPS;
  localparam int HI_CUT = MAG_W - 1 - DT_W;

  localparam logic signed [DATA_WIDTH-1:0] OUT_MIN_RST = (DATA_WIDTH >= 16) ?
    DATA_WIDTH'(-32768) : {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] OUT_MAX_RST = (DATA_WIDTH >= 16) ?
    DATA_WIDTH'(32767) : {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_HI = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_LO = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // Configuration
  logic signed [GAIN_W-1:0]     kp;
  logic signed [GAIN_W-1:0]     ki;
  logic signed [GAIN_W-1:0]     kd;
  logic signed [DATA_WIDTH-1:0] out_min;
  logic signed [DATA_WIDTH-1:0] out_max;

  // Controller state
  logic signed [ACC_WIDTH-1:0]  integral;
  logic signed [ACC_WIDTH-1:0]  integral_next;
  logic signed [E_W-1:0]        last_error;

  // Per-transaction working registers
  logic signed [E_W-1:0]        e;
  logic [DT_W-1:0]              dt_r;
  logic [PW-1:0]                prod;
  logic [PW-1:0]                plo;
  logic [PW-1:0]                phi;
  logic signed [SUM_W-1:0]      p_val;
  logic signed [SUM_W-1:0]      i_val;
  logic signed [SUM_W-1:0]      pi;
  logic signed [SUM_W-1:0]      sum;
  logic                         t_neg;

  // Combinational
  logic [E_W-1:0]               e_abs;
  logic signed [DE_W-1:0]       de;
  logic [DE_W-1:0]              de_abs;
  logic [GAIN_W-1:0]            kp_mag;
  logic [GAIN_W-1:0]            ki_mag;
  logic [GAIN_W-1:0]            kd_mag;
  logic [ACC_WIDTH-1:0]         imag;
  logic [WIDE_W-1:0]            imag_wide;
  logic [GAIN_W-1:0]            mul_a;
  logic [MB_W-1:0]              mul_b;
  logic signed [SW-1:0]         int_ext;
  logic signed [SW-1:0]         int_inc;
  logic signed [SW-1:0]         int_sum;
  logic signed [SUM_W-1:0]      p_next;
  logic [MAG_W:0]               i_raw;
  logic [MAG_W-1:0]             i_mag;
  logic signed [SUM_W-1:0]      i_next;
  logic [NUM_W-1:0]             quotient;
  logic [MAG_W-1:0]             d_mag;
  logic signed [SUM_W-1:0]      d_val;
  logic signed [SUM_W-1:0]      max_q;
  logic signed [SUM_W-1:0]      min_q;
  logic [DATA_WIDTH-1:0]        drive_next;
  logic                         clamped_next;

  assign e_abs     = e[E_W-1] ? -e : e;
  assign de        = DE_W'(e) - DE_W'(last_error);
  assign de_abs    = de[DE_W-1] ? -de : de;
  assign kp_mag    = kp[GAIN_W-1] ? -kp : kp;
  assign ki_mag    = ki[GAIN_W-1] ? -ki : ki;
  assign kd_mag    = kd[GAIN_W-1] ? -kd : kd;
  assign imag      = integral[ACC_WIDTH-1] ? -integral : integral;
  assign imag_wide = WIDE_W'(imag);

  // Shared unsigned multiplier; signs are applied when a product is consumed.
  always_comb begin
    case (cmd.mul_op)
      MUL_E_DT: begin
        mul_a = GAIN_W'(dt_r);
        mul_b = MB_W'(e_abs[DATA_WIDTH-1:0]);
      end
      MUL_KP_E: begin
        mul_a = kp_mag;
        mul_b = MB_W'(e_abs[DATA_WIDTH-1:0]);
      end
      MUL_KI_LO: begin
        mul_a = ki_mag;
        mul_b = MB_W'(imag_wide[SPLIT_W-1:0]);
      end
      MUL_KI_HI: begin
        mul_a = ki_mag;
        mul_b = MB_W'(imag_wide[WIDE_W-1:SPLIT_W]);
      end
      MUL_KD_DE: begin
        mul_a = kd_mag;
        mul_b = MB_W'(de_abs[DATA_WIDTH:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Saturating integral update with e*dt.
  always_comb begin
    int_ext = SW'(integral);
    int_inc = signed'(SW'(prod[DATA_WIDTH+DT_W-1:0]));
    if (e[E_W-1]) begin
      int_inc = -int_inc;
    end
    int_sum = int_ext + int_inc;
    if ((&int_sum[SW-1:ACC_WIDTH-1]) || !(|int_sum[SW-1:ACC_WIDTH-1])) begin
      integral_next = int_sum[ACC_WIDTH-1:0];
    end else begin
      integral_next = int_sum[SW-1] ? ACC_LO : ACC_HI;
    end
  end

  assign p_next = (kp[GAIN_W-1] ^ e[E_W-1]) ? -signed'(SUM_W'(prod)) : signed'(SUM_W'(prod));

  // Integral term: the two partial products recombined, shifted down, and limited.
  always_comb begin
    i_raw = (MAG_W+1)'({phi[HI_CUT-1:0], {DT_W{1'b0}}}) + (MAG_W+1)'(plo[PW-1:DT_W]);
    if ((phi[PW-1:HI_CUT] != '0) || (i_raw > (MAG_W+1)'(TERM_LIM))) begin
      i_mag = TERM_LIM;
    end else begin
      i_mag = i_raw[MAG_W-1:0];
    end
    i_next = signed'(SUM_W'(i_mag));
    if (ki[GAIN_W-1] ^ integral[ACC_WIDTH-1]) begin
      i_next = -i_next;
    end
  end

  pidc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DT_W)
  ) u_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (NUM_W'({prod, {DT_W{1'b0}}})),
    .divisor  (dt_r),
    .quotient (quotient)
  );

  // Derivative term; a zero time step contributes nothing.
  always_comb begin
    if ((quotient[NUM_W-1:MAG_W] != '0) || (quotient[MAG_W-1:0] > TERM_LIM)) begin
      d_mag = TERM_LIM;
    end else begin
      d_mag = quotient[MAG_W-1:0];
    end
    d_val = signed'(SUM_W'(d_mag));
    if (t_neg) begin
      d_val = -d_val;
    end
    if (dt_r == '0) begin
      d_val = '0;
    end
  end

  // The upper limit is tested first, so with inverted limits any sum above out_max resolves to out_max.
  assign max_q = SUM_W'(out_max) <<< 8;
  assign min_q = SUM_W'(out_min) <<< 8;

  always_comb begin
    if (sum > max_q) begin
      drive_next   = out_max;
      clamped_next = 1'b1;
    end else if (sum < min_q) begin
      drive_next   = out_min;
      clamped_next = 1'b1;
    end else begin
      drive_next   = sum[DATA_WIDTH+7:8];
      clamped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp         <= '0;
      ki         <= '0;
      kd         <= '0;
      out_min    <= OUT_MIN_RST;
      out_max    <= OUT_MAX_RST;
      integral   <= '0;
      last_error <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_KP:      kp      <= cfg_wdata[GAIN_W-1:0];
          REG_KI:      ki      <= cfg_wdata[GAIN_W-1:0];
          REG_KD:      kd      <= cfg_wdata[GAIN_W-1:0];
          REG_OUT_MIN: out_min <= cfg_wdata[DATA_WIDTH-1:0];
          REG_OUT_MAX: out_max <= cfg_wdata[DATA_WIDTH-1:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        integral   <= '0;
        last_error <= '0;
      end else begin
        if (cmd.int_upd) begin
          integral <= integral_next;
        end
        if (cmd.div_load) begin
          last_error <= e;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load) begin
      e    <= E_W'(setpoint) - E_W'(measured);
      dt_r <= dt;
    end
    if (cmd.p_load) begin
      p_val <= p_next;
    end
    if (cmd.plo_load) begin
      plo <= prod;
    end
    if (cmd.phi_load) begin
      phi <= prod;
    end
    if (cmd.div_load) begin
      i_val <= i_next;
      t_neg <= kd[GAIN_W-1] ^ de[DE_W-1];
    end
    if (cmd.div_step) begin
      pi <= p_val + i_val;
    end
    if (cmd.sum_load) begin
      sum <= pi + d_val;
    end
    if (cmd.out_load) begin
      drive   <= drive_next;
      clamped <= clamped_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pidc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pidc_ctrl #(
  parameter int DIV_STEPS = 36
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  input  wire logic          s_action,
  output logic               s_tready,
  input  wire logic          m_tready,
  output logic               m_tvalid,
  output pidc_pkg::pidc_cmd_t cmd
);
  import pidc_pkg::*;

  localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_EDT  = 4'd1;
  localparam logic [3:0] S_MUL_KPE  = 4'd2;
  localparam logic [3:0] S_MUL_KILO = 4'd3;
  localparam logic [3:0] S_MUL_KIHI = 4'd4;
  localparam logic [3:0] S_MUL_KDDE = 4'd5;
  localparam logic [3:0] S_DIV_LOAD = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_SUM      = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_valid;
  logic             out_valid_next;
  logic             accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  // Each multiply state issues one product; every one after the first consumes the one issued before it.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_op = MUL_E_DT;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_action) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_MUL_EDT;
          end
        end
      end
      S_MUL_EDT: begin
        cmd.mul_op = MUL_E_DT;
        state_next = S_MUL_KPE;
      end
      S_MUL_KPE: begin
        cmd.mul_op  = MUL_KP_E;
        cmd.int_upd = 1'b1;
        state_next  = S_MUL_KILO;
      end
      S_MUL_KILO: begin
        cmd.mul_op = MUL_KI_LO;
        cmd.p_load = 1'b1;
        state_next = S_MUL_KIHI;
      end
      S_MUL_KIHI: begin
        cmd.mul_op   = MUL_KI_HI;
        cmd.plo_load = 1'b1;
        state_next   = S_MUL_KDDE;
      end
      S_MUL_KDDE: begin
        cmd.mul_op   = MUL_KD_DE;
        cmd.phi_load = 1'b1;
        state_next   = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_SUM;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SUM: begin
        cmd.sum_load = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  a_rise_after_out : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT)
    else $error("result presented without passing through the output state");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !cmd.out_load)
    else $error("pending result overwritten");

  a_full_divide : assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) |-> ($past(state) == S_DIV && $past(cnt) == CNT_W'(DIV_STEPS - 1)))
    else $error("sum formed before the divide finished");

  a_cnt_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt <= CNT_W'(DIV_STEPS - 1)))
    else $error("divide step counter out of range");

endmodule

`default_nettype wire

@@ hw/rtl/pid_controller_clamped.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Positional PID step with clamped output, one sample transaction at a time.
// The result passes through five products of the shared 24-bit multiplier and a radix-4
// divider by dt; a new sample is accepted only once the previous one has reached the output
// register, and a clear transaction completes in the idle state without producing a result.
// The output register lets the next sample start while a result waits on m_tready.
// Reset (rst, synchronous) zeroes gains, integral and last error and sets full-scale limits.

module pid_controller_clamped #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // setpoint, measured, dt
  input  wire logic [((2*DATA_WIDTH+pidc_pkg::DT_W+7)/8)*8-1:0] s_tdata,
  // action
  input  wire logic s_tuser,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // drive
  output logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  // clamped
  output logic      m_tuser,
  input  wire logic cfg_we,
  input  wire logic [pidc_pkg::REG_IDX_W-1:0] cfg_addr,
  input  wire logic [((DATA_WIDTH > pidc_pkg::GAIN_W) ? DATA_WIDTH : pidc_pkg::GAIN_W)-1:0]
                    cfg_wdata
);
  import pidc_pkg::*;

  localparam int OUT_W     = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int CFG_W     = (DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W;
  localparam int MB_W      = (DATA_WIDTH + 1 > SPLIT_W) ? DATA_WIDTH + 1 : SPLIT_W;
  localparam int DIV_STEPS = (GAIN_W + MB_W + DT_W + DIV_RADIX - 1) / DIV_RADIX;

  pidc_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] drive;
  logic                  clamped;

  pidc_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_action (s_tuser),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  pidc_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH),
    .DIV_STEPS  (DIV_STEPS),
    .CFG_W      (CFG_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .setpoint  (s_tdata[DATA_WIDTH-1:0]),
    .measured  (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .dt        (s_tdata[2*DATA_WIDTH+DT_W-1:2*DATA_WIDTH]),
    .cmd       (cmd),
    .drive     (drive),
    .clamped   (clamped)
  );

  assign m_tdata = OUT_W'(drive);
  assign m_tuser = clamped;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import pidc_pkg::*;

  localparam int DW = 16;
  localparam int DRAIN_CYCLES = 60;
  localparam int RX_HOLD_CYCLES = 2000;
  localparam int WINDUP_STEPS = 40;
  localparam longint TIMEOUT_NS = 64'd30_000_000;
  localparam longint INTEG_HI = (64'sd1 <<< 47) - 1;
  localparam longint INTEG_LO = -INTEG_HI - 1;
  localparam logic [127:0] MAG_LIMIT = 128'd1 << 60;

  typedef struct {
    logic signed [DW-1:0] drive;
    logic                 clamped;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr = REG_KP;
  logic [23:0] cfg_wdata = '0;

  // Controller state and register copies as the block should hold them.
  longint gain_p = 0, gain_i = 0, gain_d = 0;
  longint lim_lo = -32768, lim_hi = 32767;
  longint prev_err = 0, integ_sum = 0;

  drive_result_t pending_drives[$];
  int n_fail = 0;
  bit tx_burst = 1'b0;
  bit rx_free = 1'b0;
  bit rx_hold_req = 1'b0;

  pid_controller_clamped dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] magnitude(input longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // Integral term: (ki * integral) / 2^16, magnitude truncated and limited to 2^60.
  function automatic longint integral_term(input longint g, input longint acc);
    logic [127:0] wide;
    longint mag;
    wide = (128'(magnitude(g)) * 128'(magnitude(acc))) >> 16;
    mag = (wide > MAG_LIMIT) ? longint'(MAG_LIMIT[63:0]) : longint'(wide[63:0]);
    return ((g < 0) != (acc < 0)) ? -mag : mag;
  endfunction

  // Derivative term: (t * 2^16) / dt with the same truncation and limit.
  function automatic longint rate_term(input longint t, input logic [15:0] dt);
    logic [127:0] wide;
    longint mag;
    wide = (128'(magnitude(t)) << 16) / 128'(dt);
    mag = (wide > MAG_LIMIT) ? longint'(MAG_LIMIT[63:0]) : longint'(wide[63:0]);
    return (t < 0) ? -mag : mag;
  endfunction

  // Advances the controller state for one accepted transaction and queues its drive unless it is a clear.
  function automatic void predict_drive(input logic act, input logic signed [15:0] sp,
                                        input logic signed [15:0] mv, input logic [15:0] dt);
    longint err, prod, sum, q;
    drive_result_t res;
    if (act) begin
      integ_sum = 0;
      prev_err = 0;
      return;
    end
    err = longint'(sp) - longint'(mv);
    prod = err * longint'(dt);
    if (prod > 0 && integ_sum > INTEG_HI - prod) integ_sum = INTEG_HI;
    else if (prod < 0 && integ_sum < INTEG_LO - prod) integ_sum = INTEG_LO;
    else integ_sum = integ_sum + prod;
    sum = gain_p * err + integral_term(gain_i, integ_sum);
    if (dt != 16'd0) sum = sum + rate_term(gain_d * (err - prev_err), dt);
    res.clamped = 1'b1;
    if (sum > lim_hi * 256) q = lim_hi;
    else if (sum < lim_lo * 256) q = lim_lo;
    else begin
      q = sum >>> 8;
      res.clamped = 1'b0;
    end
    res.drive = q[15:0];
    prev_err = err;
    pending_drives.push_back(res);
  endfunction

  function automatic longint pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return -8388608;
        1: return 8388607;
        2: return 0;
        default: return 256;
      endcase
    end
    if (r < 55) return longint'($urandom_range(0, 2048)) - 1024;
    if (r < 85) return longint'($urandom_range(0, 131072)) - 65536;
    return longint'($signed(24'($urandom)));
  endfunction

  // Called and returns at a falling edge; writes all five registers back to back.
  task automatic program_regs(input longint kp, input longint ki, input longint kd,
                              input longint lo, input longint hi);
    logic [REG_IDX_W-1:0] idx[5];
    logic [23:0] val[5];
    idx[0] = REG_KP;
    idx[1] = REG_KI;
    idx[2] = REG_KD;
    idx[3] = REG_OUT_MIN;
    idx[4] = REG_OUT_MAX;
    val[0] = 24'(kp);
    val[1] = 24'(ki);
    val[2] = 24'(kd);
    val[3] = 24'(lo);
    val[4] = 24'(hi);
    cfg_we <= 1'b1;
    for (int k = 0; k < 5; k++) begin
      cfg_addr <= idx[k];
      cfg_wdata <= val[k];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    gain_p = longint'($signed(val[0]));
    gain_i = longint'($signed(val[1]));
    gain_d = longint'($signed(val[2]));
    lim_lo = longint'($signed(val[3][15:0]));
    lim_hi = longint'($signed(val[4][15:0]));
  endtask

  task automatic send_sample(input logic act, input logic [15:0] sp, input logic [15:0] mv,
                             input logic [15:0] dt);
    int gap;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {dt, mv, sp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_drive(act, sp, mv, dt);
    @(negedge clk);
  endtask

  // A clear may still be in progress after the last result, hence the extra cycles.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_reset_values();
    send_sample(1'b0, 16'd1000, 16'd0, 16'd100);
    send_sample(1'b0, 16'h8000, 16'h7fff, 16'hffff);
  endtask

  task automatic test_directed_cases();
    wait_idle();
    program_regs(256, 256, 256, -32768, 32767);
    send_sample(1'b0, 16'd0, 16'd0, 16'd1);
    send_sample(1'b0, 16'h7fff, 16'h8000, 16'd1);
    send_sample(1'b0, 16'h8000, 16'h7fff, 16'hffff);
    send_sample(1'b0, 16'd10, 16'd3, 16'd0);
    send_sample(1'b1, 16'h5a5a, 16'ha5a5, 16'h0000);
    send_sample(1'b0, 16'd5, 16'd0, 16'd16);
    send_sample(1'b0, -16'sd5, 16'd0, 16'hffff);
    send_sample(1'b1, 16'hffff, 16'hffff, 16'hffff);
    send_sample(1'b0, 16'd100, 16'd100, 16'd2);

    // Limits swapped: the upper limit is tested first.
    wait_idle();
    program_regs(256, 0, 0, 100, -100);
    send_sample(1'b0, 16'd50, 16'd0, 16'd7);
    send_sample(1'b0, -16'sd200, 16'd0, 16'd7);

    wait_idle();
    program_regs(-8388608, 8388607, -8388608, -32768, 32767);
    send_sample(1'b1, 16'd0, 16'd0, 16'd0);
    send_sample(1'b0, 16'h7fff, 16'h8000, 16'd1);
    send_sample(1'b0, 16'h8000, 16'h7fff, 16'd1);
    send_sample(1'b0, 16'd3, 16'd1, 16'hffff);

    // Zero-width window: only an exact zero sum passes unclamped.
    wait_idle();
    program_regs(1, 0, 0, 0, 0);
    send_sample(1'b0, 16'd1, 16'd0, 16'd9);
    send_sample(1'b0, 16'd0, 16'd1, 16'd9);
    send_sample(1'b0, 16'd4, 16'd4, 16'd9);
  endtask

  // Winds the integral up with the largest error and time step, then lets the
  // derivative work against the integral term.
  task automatic test_integral_windup();
    wait_idle();
    program_regs(0, 1, 32768, -32768, 32767);
    tx_burst = 1'b1;
    rx_free = 1'b1;
    send_sample(1'b1, 16'd0, 16'd0, 16'd1);
    repeat (WINDUP_STEPS) send_sample(1'b0, 16'h7fff, 16'h8000, 16'hffff);
    send_sample(1'b0, 16'd0, 16'd0, 16'hffff);
    send_sample(1'b0, 16'h8000, 16'h7fff, 16'hffff);
    send_sample(1'b1, 16'd0, 16'd0, 16'd1);
    tx_burst = 1'b0;
    rx_free = 1'b0;
  endtask

  task automatic test_backpressure();
    wait_idle();
    program_regs(300, -40, 900, -20000, 20000);
    tx_burst = 1'b1;
    rx_hold_req = 1'b1;
    repeat (16) send_sample(1'b0, 16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
    tx_burst = 1'b0;
  endtask

  task automatic test_random_phase(input int phase, input int n_items);
    longint lo, hi;
    logic act;
    logic [15:0] sp, mv, dt;
    int r;
    wait_idle();
    r = $urandom_range(0, 99);
    if (r < 25) begin
      lo = -32768;
      hi = 32767;
    end else if (r < 40) begin
      lo = longint'($signed(16'($urandom)));
      hi = longint'($signed(16'($urandom)));
    end else begin
      lo = -longint'($urandom_range(0, 32768));
      hi = longint'($urandom_range(0, 32767));
    end
    case (phase)
      0: program_regs(8388607, -8388608, 8388607, -32768, 32767);
      1: program_regs(-8388608, -8388608, -8388608, 32767, -32768);
      default: program_regs(pick_gain(), pick_gain(), pick_gain(), lo, hi);
    endcase
    tx_burst = ($urandom_range(0, 3) == 0);
    rx_free = ($urandom_range(0, 3) == 0);
    repeat (n_items) begin
      act = ($urandom_range(0, 99) < 8);
      sp = 16'($urandom);
      if ($urandom_range(0, 99) < 40) mv = sp + 16'($urandom_range(0, 600)) - 16'd300;
      else mv = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 3) dt = 16'd0;
      else if (r < 10) dt = 16'd1;
      else if (r < 17) dt = 16'hffff;
      else if (r < 55) dt = 16'($urandom_range(1, 64));
      else dt = 16'($urandom);
      send_sample(act, sp, mv, dt);
    end
    tx_burst = 1'b0;
    rx_free = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_values();
    test_directed_cases();
    test_backpressure();
    test_integral_windup();
    for (int ph = 0; ph < 6; ph++) test_random_phase(ph, 60);
    wait_idle();
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: random stalls, free-running stretches, and one long hold on request.
  initial begin : result_sink
    int rx_wait;
    rx_wait = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_wait = RX_HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait--;
      end else if (rx_free || $urandom_range(0, 99) < 75) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_wait = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_results
    drive_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_drives.size() == 0) begin
        $error("result transaction with nothing pending: drive %0d, clamped %0b",
               $signed(m_tdata[15:0]), m_tuser);
        n_fail++;
      end else begin
        want = pending_drives.pop_front();
        if (m_tdata[15:0] !== want.drive) begin
          $error("drive mismatch: expected %0d, actual %0d", want.drive,
                 $signed(m_tdata[15:0]));
          n_fail++;
        end
        if (m_tuser !== want.clamped) begin
          $error("clamped mismatch: expected %0b, actual %0b", want.clamped, m_tuser);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
